@@ src/ial_pkg.sv @@
`default_nettype none

package ial_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } ial_cmd_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } ial_cell_op_e;

  typedef logic [31:0] ial_word_t;

  typedef struct packed {
    ial_cmd_e    cmd;
    logic [7:0]  slot_index;
    logic [7:0]  first_octet;
    logic [7:0]  second_octet;
    logic [7:0]  third_octet;
    logic [7:0]  fourth_octet;
  } ial_in_t;

  typedef struct packed {
    logic [7:0]  read_first;
    logic [7:0]  read_second;
    logic [7:0]  read_third;
    logic [7:0]  read_fourth;
    logic [4:0]  list_length;
    logic        op_error;
  } ial_out_t;

endpackage

`default_nettype wire

@@ src/indexed_address_list_unit.sv @@
// Channel  Direction  Handshake          Payload
// command  in         start, busy        req_i (ial_in_t)
// result   out        done_o strobe      rsp_o (ial_out_t)
//
// A command is taken at each rising edge with start high; busy stays low,
// so one command can follow another in every cycle.
// The result appears in the cycle after acceptance, for one cycle, held in
// the result register behind the cell row; every cell shifts in parallel.
// Reset empties the list; entry contents are undefined until written.
// The receiver cannot stall the result strobe.
`default_nettype none

module indexed_address_list_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ial_pkg::ial_in_t req_i,
  output logic             done_o,
  output ial_pkg::ial_out_t rsp_o
);
  import ial_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            done_q;
  ial_out_t        rsp_q;
  ial_out_t        rsp_d;

  logic            accept;
  logic            is_ins;
  logic            err;
  logic            do_ins;
  logic            do_rm;
  logic            full;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] eff_pos;
  ial_word_t       new_word;
  ial_word_t       rd_word;

  ial_word_t       cell_data [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign pos_ext  = CmpW'(req_i.slot_index);
  assign cnt_ext  = CmpW'(count_q);
  assign full     = (count_q >= CntW'(CAPACITY));
  assign is_ins   = (req_i.cmd == CMD_APPEND) || (req_i.cmd == CMD_INSERT);
  assign eff_pos  = (req_i.cmd == CMD_APPEND) ? cnt_ext : pos_ext;
  assign new_word = {req_i.first_octet, req_i.second_octet,
                     req_i.third_octet, req_i.fourth_octet};

  always_comb begin
    unique case (req_i.cmd)
      CMD_APPEND: err = full;
      CMD_INSERT: err = full || (pos_ext > cnt_ext);
      CMD_REMOVE: err = (pos_ext >= cnt_ext);
      CMD_READ:   err = (pos_ext >= cnt_ext);
      default:    err = 1'b1;
    endcase
  end

  assign do_ins = accept && is_ins && !err;
  assign do_rm  = accept && (req_i.cmd == CMD_REMOVE) && !err;

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rm) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CmpW-1:0] Pos = CmpW'(i);
    ial_cell_op_e op;
    ial_word_t    prev_w;
    ial_word_t    next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_data[i+1];
    end

    always_comb begin
      priority if (do_ins && (Pos == eff_pos)) begin
        op = CELL_LOAD;
      end else if (do_ins && (Pos > eff_pos)) begin
        op = CELL_FROM_PREV;
      end else if (do_rm && (Pos >= eff_pos)) begin
        op = CELL_FROM_NEXT;
      end else begin
        op = CELL_HOLD;
      end
    end

    ial_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .load_i (new_word),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i])
    );
  end

  assign rd_word = cell_data[req_i.slot_index[IdxW-1:0]];

  always_comb begin
    rsp_d             = '0;
    rsp_d.list_length = 5'(count_d);
    rsp_d.op_error    = err;
    if ((req_i.cmd == CMD_READ) && !err) begin
      rsp_d.read_first  = rd_word[31:24];
      rsp_d.read_second = rd_word[23:16];
      rsp_d.read_third  = rd_word[15:8];
      rsp_d.read_fourth = rd_word[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTH
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result strobe without accepted command");

  a_accept_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted command produced no result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.op_error) |-> (count_q == $past(count_q)))
    else $error("refused command changed the length");

  a_error_zero_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.op_error) |-> (rsp_o.read_first == 8'd0 &&
      rsp_o.read_second == 8'd0 && rsp_o.read_third == 8'd0 &&
      rsp_o.read_fourth == 8'd0))
    else $error("refused command returned read data");
`endif

endmodule

`default_nettype wire

@@ src/ial_cell.sv @@
`default_nettype none

module ial_cell (
  input  logic                  clk_i,
  input  ial_pkg::ial_cell_op_e op_i,
  input  ial_pkg::ial_word_t    load_i,
  input  ial_pkg::ial_word_t    prev_i,
  input  ial_pkg::ial_word_t    next_i,
  output ial_pkg::ial_word_t    data_o
);
  import ial_pkg::*;

  ial_word_t data_q;
  ial_word_t data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:      data_d = data_q;
      CELL_LOAD:      data_d = load_i;
      CELL_FROM_PREV: data_d = prev_i;
      CELL_FROM_NEXT: data_d = next_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ial_pkg::*;

  localparam int CAPACITY = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_WORDS = 450;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ial_in_t   req_i;
  logic      done_o;
  ial_out_t  rsp_o;

  ial_in_t   pending_words[$];
  ial_out_t  expected_results[$];

  ial_word_t stored_addrs[CAPACITY];
  int        stored_len;
  int        gen_len;
  int        mismatches;
  int        idle_cycles;
  int        burst_left;
  int        gap_left;

  indexed_address_list_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic ial_out_t apply_command(ial_in_t w);
    ial_out_t  r;
    ial_cmd_e  op;
    int        pos;
    ial_word_t addr;
    r = '0;
    op = w.cmd;
    pos = int'(w.slot_index);
    addr = {w.first_octet, w.second_octet, w.third_octet, w.fourth_octet};
    if (op == CMD_APPEND) begin
      pos = stored_len;
      op = CMD_INSERT;
    end
    case (op)
      CMD_INSERT: begin
        if (stored_len >= CAPACITY || pos > stored_len) begin
          r.op_error = 1'b1;
        end else begin
          for (int i = stored_len; i > pos; i--) stored_addrs[i] = stored_addrs[i-1];
          stored_addrs[pos] = addr;
          stored_len++;
        end
      end
      CMD_REMOVE: begin
        if (pos >= stored_len) begin
          r.op_error = 1'b1;
        end else begin
          for (int i = pos; i + 1 < stored_len; i++) stored_addrs[i] = stored_addrs[i+1];
          stored_len--;
        end
      end
      default: begin
        if (pos >= stored_len) begin
          r.op_error = 1'b1;
        end else begin
          {r.read_first, r.read_second, r.read_third, r.read_fourth} = stored_addrs[pos];
        end
      end
    endcase
    r.list_length = stored_len[4:0];
    return r;
  endfunction

  task automatic queue_word(ial_cmd_e op, int slot, ial_word_t addr);
    ial_in_t w;
    w.cmd = op;
    w.slot_index = slot[7:0];
    {w.first_octet, w.second_octet, w.third_octet, w.fourth_octet} = addr;
    pending_words.push_back(w);
    case (op)
      CMD_APPEND: if (gen_len < CAPACITY) gen_len++;
      CMD_INSERT: if (gen_len < CAPACITY && slot <= gen_len) gen_len++;
      CMD_REMOVE: if (slot < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    bit      accepted;
    bit      next_start;
    ial_in_t next_req;
    accepted = rst_ni && start && !busy;
    next_start = start;
    next_req = req_i;
    if (!rst_ni) begin
      next_start = 1'b0;
    end else begin
      if (accepted) begin
        expected_results.push_back(apply_command(pending_words[0]));
        pending_words.delete(0);
      end
      if (!start || accepted) begin
        next_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          next_start = 1'b1;
          next_req = pending_words[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end
        end
      end
    end
    start <= next_start;
    req_i <= next_req;
  end

  always @(posedge clk_i) begin
    ial_out_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, rsp_o);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("read_first", int'(want.read_first), int'(rsp_o.read_first));
        check_field("read_second", int'(want.read_second), int'(rsp_o.read_second));
        check_field("read_third", int'(want.read_third), int'(rsp_o.read_third));
        check_field("read_fourth", int'(want.read_fourth), int'(rsp_o.read_fourth));
        check_field("list_length", int'(want.list_length), int'(rsp_o.list_length));
        check_field("op_error", int'(want.op_error), int'(rsp_o.op_error));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int        phase;
    int        phase_left;
    int        roll;
    int        slot;
    ial_cmd_e  op;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    stored_len = 0;
    gen_len = 0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = $urandom_range(40, 1);
    gap_left = 0;
    foreach (stored_addrs[i]) stored_addrs[i] = '0;

    queue_word(CMD_READ, 0, $urandom());
    queue_word(CMD_REMOVE, 0, $urandom());
    queue_word(CMD_INSERT, 1, $urandom());
    queue_word(CMD_INSERT, 0, 32'h0102_0304);
    queue_word(CMD_APPEND, 255, 32'hFFFF_FFFF);
    queue_word(CMD_INSERT, 2, 32'h0000_0000);
    queue_word(CMD_INSERT, 1, 32'hC0A8_0001);
    queue_word(CMD_READ, 0, 32'hFFFF_FFFF);
    queue_word(CMD_READ, 3, 32'h0000_0000);
    queue_word(CMD_READ, 4, $urandom());
    queue_word(CMD_READ, 255, $urandom());
    queue_word(CMD_REMOVE, 1, $urandom());
    queue_word(CMD_REMOVE, 2, $urandom());
    queue_word(CMD_REMOVE, 255, $urandom());
    queue_word(CMD_READ, 1, $urandom());

    phase = 0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase = $urandom_range(2);
        phase_left = $urandom_range(40, 10);
      end
      phase_left--;
      roll = $urandom_range(99);
      if (roll < 12) begin
        op = ial_cmd_e'($urandom_range(3));
        slot = $urandom_range(255);
      end else begin
        roll = $urandom_range(99);
        case (phase)
          0: op = (roll < 35) ? CMD_APPEND : (roll < 70) ? CMD_INSERT :
                  (roll < 85) ? CMD_READ : CMD_REMOVE;
          1: op = (roll < 65) ? CMD_REMOVE : (roll < 85) ? CMD_READ :
                  (roll < 93) ? CMD_APPEND : CMD_INSERT;
          default: op = ial_cmd_e'(roll % 4);
        endcase
        case (op)
          CMD_INSERT: slot = $urandom_range(gen_len);
          CMD_APPEND: slot = $urandom_range(255);
          default: slot = (gen_len > 0) ? $urandom_range(gen_len - 1) : $urandom_range(255);
        endcase
      end
      queue_word(op, slot, $urandom());
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/ial_pkg.sv
src/ial_cell.sv
src/indexed_address_list_unit.sv
test/tb_top.sv
